// File: hdl/segment_overlap_percent_assert.svh
// assertion macros for the segment overlap block
// expects clk and rst_n in the scope of use
`ifndef SEGMENT_OVERLAP_PERCENT_ASSERT_SVH
`define SEGMENT_OVERLAP_PERCENT_ASSERT_SVH

`define SOP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SOP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hdl/sop_pkg.sv
// shared types and constants of the segment overlap block
// no dependencies
package sop_pkg;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'b00,
        KIND_FULL = 2'b01,
        KIND_PART = 2'b10
    } kind_t;

    localparam int          QW           = 7;
    localparam logic [6:0]  FULL_PERCENT = 7'd100;
    localparam logic [6:0]  SAT_FACTOR   = 7'd101;
    localparam logic [7:0]  TOL_RESET    = 8'd11;

endpackage

// File: hdl/sop_isqrt.sv
// pipelined integer square root, one result bit per stage
// no package dependencies
module sop_isqrt #(
    parameter int IW = 27,
    localparam int RW = (IW + 1) / 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [IW-1:0] radicand,
    output logic          out_valid,
    output logic [RW-1:0] root
);

    localparam int IW2 = 2 * RW;
    localparam logic [IW2-1:0] ONE = IW2'(1);

    logic [IW2-1:0] rem_reg   [RW];
    logic [IW2-1:0] root_reg  [RW];
    logic [IW2-1:0] rem_next  [RW];
    logic [IW2-1:0] root_next [RW];
    logic [IW2-1:0] v_in      [RW];
    logic [IW2-1:0] r_in      [RW];
    logic [RW-1:0]  vld_reg;
    logic [RW-1:0]  vld_next;

    always_comb
    begin
        v_in[0] = IW2'(radicand);
        r_in[0] = '0;
        for (int k = 1; k < RW; k++)
        begin
            v_in[k] = rem_reg[k-1];
            r_in[k] = root_reg[k-1];
        end
    end

    always_comb
    begin
        logic [IW2-1:0] b;
        for (int k = 0; k < RW; k++)
        begin
            b = ONE << (IW2 - 2 - 2 * k);
            if (v_in[k] >= r_in[k] + b)
            begin
                rem_next[k]  = v_in[k] - (r_in[k] + b);
                root_next[k] = (r_in[k] >> 1) + b;
            end
            else
            begin
                rem_next[k]  = v_in[k];
                root_next[k] = r_in[k] >> 1;
            end
        end
    end

    assign vld_next = {vld_reg[RW-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RW; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1][RW-1:0];

endmodule

// File: hdl/sop_div.sv
// pipelined share divider: floor(100 * d / lb), saturated, one quotient bit per stage
// depends on sop_pkg
module sop_div #(
    parameter int RW = 14
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  sop_pkg::kind_t kind,
    input  logic [RW-1:0]  d,
    input  logic [RW-1:0]  lb,
    output logic           out_valid,
    output logic [6:0]     percent
);

    import sop_pkg::*;

    localparam int NW = RW + QW;

    logic          v1_reg, v2_reg, vo_reg;
    logic [NW-1:0] num1_reg, l1_reg;
    logic [RW-1:0] lb1_reg, lb2_reg;
    logic          lbz1_reg, lbz2_reg, sat2_reg;
    kind_t         kind1_reg, kind2_reg;
    logic [NW-1:0] rem2_reg;

    logic [QW-1:0] vs_reg;
    logic [NW-1:0] rem_s_reg  [QW];
    logic [QW-1:0] q_s_reg    [QW];
    logic [RW-1:0] lb_s_reg   [QW];
    logic          lbz_s_reg  [QW];
    logic          sat_s_reg  [QW];
    kind_t         kind_s_reg [QW];

    logic [NW-1:0] rem_in   [QW];
    logic [QW-1:0] q_in     [QW];
    logic [RW-1:0] lb_in    [QW];
    logic          lbz_in   [QW];
    logic          sat_in   [QW];
    kind_t         kind_in  [QW];
    logic [NW-1:0] rem_next [QW];
    logic [QW-1:0] q_next   [QW];
    logic [6:0]    percent_reg, percent_next;

    always_comb
    begin
        rem_in[0]  = rem2_reg;
        q_in[0]    = '0;
        lb_in[0]   = lb2_reg;
        lbz_in[0]  = lbz2_reg;
        sat_in[0]  = sat2_reg;
        kind_in[0] = kind2_reg;
        for (int k = 1; k < QW; k++)
        begin
            rem_in[k]  = rem_s_reg[k-1];
            q_in[k]    = q_s_reg[k-1];
            lb_in[k]   = lb_s_reg[k-1];
            lbz_in[k]  = lbz_s_reg[k-1];
            sat_in[k]  = sat_s_reg[k-1];
            kind_in[k] = kind_s_reg[k-1];
        end
    end

    always_comb
    begin
        logic [NW-1:0] sh;
        for (int k = 0; k < QW; k++)
        begin
            sh = NW'(lb_in[k]) << (QW - 1 - k);
            if (rem_in[k] >= sh)
            begin
                rem_next[k] = rem_in[k] - sh;
                q_next[k]   = {q_in[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_in[k];
                q_next[k]   = {q_in[k][QW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        case (kind_s_reg[QW-1])
            KIND_FULL: percent_next = FULL_PERCENT;
            KIND_PART:
            begin
                if (lbz_s_reg[QW-1])
                    percent_next = '0;
                else if (sat_s_reg[QW-1])
                    percent_next = FULL_PERCENT;
                else
                    percent_next = q_s_reg[QW-1];
            end
            default:   percent_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vs_reg <= '0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            vs_reg <= {vs_reg[QW-2:0], v2_reg};
            vo_reg <= vs_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        num1_reg  <= NW'(d) * NW'(FULL_PERCENT);
        l1_reg    <= NW'(lb) * NW'(SAT_FACTOR);
        lb1_reg   <= lb;
        lbz1_reg  <= (lb == '0);
        kind1_reg <= kind;

        rem2_reg  <= num1_reg;
        sat2_reg  <= (num1_reg >= l1_reg);
        lb2_reg   <= lb1_reg;
        lbz2_reg  <= lbz1_reg;
        kind2_reg <= kind1_reg;

        for (int k = 0; k < QW; k++)
        begin
            rem_s_reg[k]  <= rem_next[k];
            q_s_reg[k]    <= q_next[k];
            lb_s_reg[k]   <= lb_in[k];
            lbz_s_reg[k]  <= lbz_in[k];
            sat_s_reg[k]  <= sat_in[k];
            kind_s_reg[k] <= kind_in[k];
        end

        percent_reg <= percent_next;
    end

    assign out_valid = vo_reg;
    assign percent   = percent_reg;

endmodule

// File: hdl/segment_overlap_percent.sv
// throughput: one request per cycle, busy is never raised; set by the fully pipelined
// cross-product, square root and divider stages
// reset: clears every valid bit and loads tolerance with 11; the receiver cannot stall
// top level of the segment overlap block; uses sop_pkg, sop_isqrt, sop_div
module segment_overlap_percent #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [7:0]                   cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] a_begin_x,
    input  logic signed [COORD_BITS-1:0] a_begin_y,
    input  logic signed [COORD_BITS-1:0] a_end_x,
    input  logic signed [COORD_BITS-1:0] a_end_y,
    input  logic signed [COORD_BITS-1:0] b_begin_x,
    input  logic signed [COORD_BITS-1:0] b_begin_y,
    input  logic signed [COORD_BITS-1:0] b_end_x,
    input  logic signed [COORD_BITS-1:0] b_end_y,
    output logic                         done,
    output logic [6:0]                   overlap_percent
);

    import sop_pkg::*;

    localparam int N    = COORD_BITS;
    localparam int DW   = N + 1;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int SW   = (XW > 32) ? 32 : XW;
    localparam int TW   = 17;
    localparam int HW   = TW + XW;
    localparam int CW   = (2 * SW > HW) ? 2 * SW : HW;
    localparam int RW   = (XW + 1) / 2;
    localparam int WW   = N + 2;
    localparam int LATENCY = N + 17;

    logic [7:0] tol_reg;

    // stage 0: request register
    logic signed [N-1:0] abx_reg, aby_reg, aex_reg, aey_reg;
    logic signed [N-1:0] bbx_reg, bby_reg, bex_reg, bey_reg;
    logic [5:0] vld_reg;

    // stage 1: differences and windows
    logic signed [DW-1:0] adx_reg, ady_reg, bdx_reg, bdy_reg;
    logic signed [DW-1:0] px_reg [4], py_reg [4];
    logic signed [DW-1:0] d3x_reg, d3y_reg;
    logic [3:0] win1_reg;
    logic signed [DW-1:0] adx_next, ady_next, bdx_next, bdy_next;
    logic signed [DW-1:0] px_next [4], py_next [4];
    logic [3:0] win_next;

    // stage 2: products
    logic signed [PW-1:0] ma_reg [4], mb_reg [4];
    logic signed [PW-1:0] lax_reg, lay_reg, lbx_reg, lby_reg;
    logic signed [PW-1:0] dsx_reg [4], dsy_reg [4];
    logic [TW-1:0] t1sq2_reg;
    logic [3:0] win2_reg;

    // stage 3: cross magnitudes and squared lengths
    logic [SW-1:0] magl_reg [4];
    logic [3:0]    hi3_reg;
    logic [XW-1:0] len2a_reg, len2b3_reg;
    logic [XW-1:0] d2_3_reg [4];
    logic [TW-1:0] t1sq3_reg;
    logic [3:0]    win3_reg;

    // stage 4: squared comparisons
    logic [2*SW-1:0] msq_reg [4];
    logic [HW-1:0]   rhsa_reg, rhsb_reg;
    logic [XW-1:0]   d2_4_reg [4];
    logic [XW-1:0]   len2b4_reg;
    logic [3:0]      hi4_reg, win4_reg;

    // stage 5: decision
    kind_t         kind5_reg, kind_next;
    logic [XW-1:0] dsel5_reg, dsel_next;
    logic [XW-1:0] lb2_5_reg;
    logic [3:0]    on_seg;

    kind_t kind_dly_reg [RW];

    logic          sq_valid;
    logic          lb_valid;
    logic [RW-1:0] d_root, lb_root;
    logic          div_valid;
    logic [6:0]    div_percent;

    function automatic logic signed [DW-1:0] sub_c(
        input logic signed [N-1:0] a,
        input logic signed [N-1:0] b
    );
        return {a[N-1], a} - {b[N-1], b};
    endfunction

    function automatic logic signed [WW-1:0] ext_c(input logic signed [N-1:0] a);
        return {{2{a[N-1]}}, a};
    endfunction

    function automatic logic window(
        input logic signed [N-1:0]  px,
        input logic signed [N-1:0]  py,
        input logic signed [N-1:0]  bx,
        input logic signed [N-1:0]  by,
        input logic signed [N-1:0]  ex,
        input logic signed [N-1:0]  ey,
        input logic signed [DW-1:0] dx,
        input logic signed [DW-1:0] dy,
        input logic [7:0]           t
    );
        logic signed [WW-1:0] tt;
        logic pos;
        logic in_x;
        logic in_y;
        tt   = $signed({{(WW-8){1'b0}}, t});
        in_x = (ext_c(px) + tt > ext_c(bx)) && (ext_c(px) - tt < ext_c(ex));
        // vertical upward counts as positive slope
        pos  = (dy > 0 && dx >= 0) || (dy < 0 && dx < 0);
        if (pos)
            in_y = (ext_c(py) - tt < ext_c(ey)) && (ext_c(py) + tt > ext_c(by));
        else
            in_y = (ext_c(py) - tt < ext_c(by)) && (ext_c(py) + tt > ext_c(ey));
        return in_x && in_y;
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[4:0], start};
    end

    // stage 1 logic
    // test 0: a begin on b, 1: a end on b, 2: b begin on a, 3: b end on a
    always_comb
    begin
        adx_next   = sub_c(aex_reg, abx_reg);
        ady_next   = sub_c(aey_reg, aby_reg);
        bdx_next   = sub_c(bex_reg, bbx_reg);
        bdy_next   = sub_c(bey_reg, bby_reg);
        px_next[0] = sub_c(abx_reg, bbx_reg);
        py_next[0] = sub_c(aby_reg, bby_reg);
        px_next[1] = sub_c(aex_reg, bbx_reg);
        py_next[1] = sub_c(aey_reg, bby_reg);
        px_next[2] = sub_c(bbx_reg, abx_reg);
        py_next[2] = sub_c(bby_reg, aby_reg);
        px_next[3] = sub_c(bex_reg, abx_reg);
        py_next[3] = sub_c(bey_reg, aby_reg);
        win_next[0] = window(abx_reg, aby_reg, bbx_reg, bby_reg, bex_reg, bey_reg,
                             bdx_next, bdy_next, tol_reg);
        win_next[1] = window(aex_reg, aey_reg, bbx_reg, bby_reg, bex_reg, bey_reg,
                             bdx_next, bdy_next, tol_reg);
        win_next[2] = window(bbx_reg, bby_reg, abx_reg, aby_reg, aex_reg, aey_reg,
                             adx_next, ady_next, tol_reg);
        win_next[3] = window(bex_reg, bey_reg, abx_reg, aby_reg, aex_reg, aey_reg,
                             adx_next, ady_next, tol_reg);
    end

    // stage 5 logic
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            on_seg[i] = win4_reg[i] && !hi4_reg[i] && (CW'(msq_reg[i]) < CW'(i < 2 ? rhsb_reg
                                                                            : rhsa_reg));
        kind_next = KIND_ZERO;
        dsel_next = d2_4_reg[0];
        if (on_seg[0])
        begin
            if (on_seg[1])
                kind_next = KIND_FULL;
            else if (on_seg[2])
            begin
                kind_next = on_seg[3] ? KIND_FULL : KIND_PART;
                dsel_next = d2_4_reg[0];
            end
            else if (on_seg[3])
            begin
                kind_next = KIND_PART;
                dsel_next = d2_4_reg[1];
            end
        end
        else if (on_seg[2])
        begin
            if (on_seg[3])
                kind_next = KIND_FULL;
            else if (on_seg[1])
            begin
                kind_next = KIND_PART;
                dsel_next = d2_4_reg[2];
            end
        end
        else if (on_seg[3])
        begin
            if (on_seg[1])
            begin
                kind_next = KIND_PART;
                dsel_next = d2_4_reg[3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [XW-1:0] cr;
        logic [XW-1:0] mag;

        abx_reg <= a_begin_x;
        aby_reg <= a_begin_y;
        aex_reg <= a_end_x;
        aey_reg <= a_end_y;
        bbx_reg <= b_begin_x;
        bby_reg <= b_begin_y;
        bex_reg <= b_end_x;
        bey_reg <= b_end_y;

        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        bdx_reg  <= bdx_next;
        bdy_reg  <= bdy_next;
        for (int i = 0; i < 4; i++)
        begin
            px_reg[i] <= px_next[i];
            py_reg[i] <= py_next[i];
        end
        d3x_reg  <= sub_c(aex_reg, bex_reg);
        d3y_reg  <= sub_c(aey_reg, bey_reg);
        win1_reg <= win_next;

        for (int i = 0; i < 2; i++)
        begin
            ma_reg[i] <= bdx_reg * py_reg[i];
            mb_reg[i] <= bdy_reg * px_reg[i];
        end
        for (int i = 2; i < 4; i++)
        begin
            ma_reg[i] <= adx_reg * py_reg[i];
            mb_reg[i] <= ady_reg * px_reg[i];
        end
        lax_reg    <= adx_reg * adx_reg;
        lay_reg    <= ady_reg * ady_reg;
        lbx_reg    <= bdx_reg * bdx_reg;
        lby_reg    <= bdy_reg * bdy_reg;
        // distances: b begin - a begin, b end - a begin, a end - b begin, a end - b end
        dsx_reg[0] <= px_reg[2] * px_reg[2];
        dsy_reg[0] <= py_reg[2] * py_reg[2];
        dsx_reg[1] <= px_reg[3] * px_reg[3];
        dsy_reg[1] <= py_reg[3] * py_reg[3];
        dsx_reg[2] <= px_reg[1] * px_reg[1];
        dsy_reg[2] <= py_reg[1] * py_reg[1];
        dsx_reg[3] <= d3x_reg * d3x_reg;
        dsy_reg[3] <= d3y_reg * d3y_reg;
        t1sq2_reg  <= TW'({1'b0, tol_reg} + 9'd1) * TW'({1'b0, tol_reg} + 9'd1);
        win2_reg   <= win1_reg;

        for (int i = 0; i < 4; i++)
        begin
            cr  = {ma_reg[i][PW-1], ma_reg[i]} - {mb_reg[i][PW-1], mb_reg[i]};
            mag = cr[XW-1] ? XW'(-cr) : XW'(cr);
            magl_reg[i] <= mag[SW-1:0];
            hi3_reg[i]  <= (mag >> SW) != '0;
            d2_3_reg[i] <= {1'b0, dsx_reg[i]} + {1'b0, dsy_reg[i]};
        end
        len2a_reg  <= {1'b0, lax_reg} + {1'b0, lay_reg};
        len2b3_reg <= {1'b0, lbx_reg} + {1'b0, lby_reg};
        t1sq3_reg  <= t1sq2_reg;
        win3_reg   <= win2_reg;

        for (int i = 0; i < 4; i++)
        begin
            msq_reg[i]  <= (2*SW)'(magl_reg[i]) * (2*SW)'(magl_reg[i]);
            d2_4_reg[i] <= d2_3_reg[i];
        end
        rhsa_reg   <= HW'(t1sq3_reg) * HW'(len2a_reg);
        rhsb_reg   <= HW'(t1sq3_reg) * HW'(len2b3_reg);
        len2b4_reg <= len2b3_reg;
        hi4_reg    <= hi3_reg;
        win4_reg   <= win3_reg;

        kind5_reg  <= kind_next;
        dsel5_reg  <= dsel_next;
        lb2_5_reg  <= len2b4_reg;

        kind_dly_reg[0] <= kind5_reg;
        for (int k = 1; k < RW; k++)
            kind_dly_reg[k] <= kind_dly_reg[k-1];
    end

    sop_isqrt #(
        .IW (XW)
    ) u_sqrt_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[5]),
        .radicand  (dsel5_reg),
        .out_valid (sq_valid),
        .root      (d_root)
    );

    sop_isqrt #(
        .IW (XW)
    ) u_sqrt_lb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[5]),
        .radicand  (lb2_5_reg),
        .out_valid (lb_valid),
        .root      (lb_root)
    );

    sop_div #(
        .RW (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .kind      (kind_dly_reg[RW-1]),
        .d         (d_root),
        .lb        (lb_root),
        .out_valid (div_valid),
        .percent   (div_percent)
    );

    assign done            = div_valid;
    assign overlap_percent = div_percent;

    `include "segment_overlap_percent_assert.svh"

    `SOP_ASSERT_IMPLY(a_pct_range, done, overlap_percent <= FULL_PERCENT, "overlap above 100")
    `SOP_ASSERT_IMPLY(a_done_origin, done, $past(start, LATENCY + 1), "result without request")
    `SOP_ASSERT_NEVER(a_never_busy, busy, "busy raised")
    `SOP_ASSERT_NEVER(a_sqrt_sync, sq_valid != lb_valid, "square root valids apart")

endmodule
